[rtl/core/pcbs_pkg.sv]
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared types, codes and sizes of the per-class band statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbs_pkg;

    // default sizes
    localparam int CLASSES_DEF     = 64;
    localparam int BANDS_DEF       = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field and accumulator widths
    localparam int FIELD_W = 16;
    localparam int SUM_W   = 48;
    localparam int SQ_W    = 64;
    localparam int CNT_W   = 32;
    localparam int Q_W     = 24;
    localparam int MEAN_W  = SUM_W + 8;
    localparam int DVD_W   = SQ_W + 16;

    // operation codes of an input beat
    localparam logic [1:0] FUNC_ACC   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // register index (address bit 2)
    localparam logic REG_NODATA_EN  = 1'b0;
    localparam logic REG_NODATA_VAL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV_MEAN,
        ST_DIV_MSQ,
        ST_SQRT,
        ST_OUT
    } state_t;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

[rtl/core/pcbs_ram.sv]
// ----------------------------------------------------------------------------
// pcbs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/pcbs_div.sv]
// ----------------------------------------------------------------------------
// pcbs_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbs_div #(
    parameter int DVD_W = pcbs_pkg::DVD_W,
    parameter int DVS_W = pcbs_pkg::CNT_W
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [DVD_W-1:0]    dividend,
    input  wire logic [DVS_W-1:0]    divisor,
    output logic      [DVD_W-1:0]    quotient,
    output pcbs_pkg::unit_stat_t     stat
);

    localparam int CNT_AW = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_AW-1:0] cnt_reg;
    logic [DVS_W:0]    rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    shifted;
    logic              ge;
    logic [DVS_W:0]    diff;

    // trial subtraction
    assign shifted = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_AW'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_AW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff : shifted;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

[rtl/core/pcbs_sqrt.sv]
// ----------------------------------------------------------------------------
// pcbs_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbs_sqrt #(
    parameter int W = pcbs_pkg::SQ_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [W-1:0]      radicand,
    output logic      [W/2-1:0]    root,
    output pcbs_pkg::unit_stat_t   stat
);

    localparam int ROOT_W = W / 2;
    localparam int REM_W  = ROOT_W + 4;
    localparam int CNT_AW = $clog2(ROOT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_AW-1:0] cnt_reg;
    logic [W-1:0]      v_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // bring down two bits, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], v_reg[W-1:W-2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_AW'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_AW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            v_reg    <= {v_reg[W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
        end
    end

    assign root = root_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

[rtl/core/per_class_band_statistics.sv]
// ----------------------------------------------------------------------------
// per_class_band_statistics
// Per-class, per-band pixel statistics: count, sum, sum of squares, min, max.
// ----------------------------------------------------------------------------
// One input beat is handled at a time. An accumulate beat reads the count
// memory and the band entry memory, then updates the entry and writes it
// back. A read beat for a class that holds pixels runs a pass of the serial
// divider each for mean and mean square, then the serial square root; any
// read beat then holds while an earlier result still waits in the output
// register. A clear beat sweeps the count memory to zero; the same sweep
// runs after reset, and no beat is accepted while it runs. Band entries are
// not cleared: the first pixel of a class overwrites them. A finished
// result waits in the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_band_statistics #(
    parameter int CLASSES     = pcbs_pkg::CLASSES_DEF,
    parameter int BANDS       = pcbs_pkg::BANDS_DEF,
    parameter int SAMPLE_BITS = pcbs_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic signed [15:0] s_class_id,
    input  wire logic [5:0]  s_band_index,
    input  wire logic [15:0] s_sample,
    input  wire logic        s_last_band,
    // result beats
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_status,
    output logic      [31:0] m_pixel_count,
    output logic      [15:0] m_band_min,
    output logic      [15:0] m_band_max,
    output logic      [23:0] m_band_mean,
    output logic      [23:0] m_band_stddev
);

    localparam int CLS_AW   = $clog2(CLASSES);
    localparam int ENTRIES  = CLASSES * BANDS;
    localparam int ENT_AW   = $clog2(ENTRIES);
    localparam int VAL_BITS = (SAMPLE_BITS < pcbs_pkg::FIELD_W) ? SAMPLE_BITS
                                                                : pcbs_pkg::FIELD_W;
    localparam int SUM_W    = pcbs_pkg::SUM_W;
    localparam int SQ_W     = pcbs_pkg::SQ_W;
    localparam int CNT_W    = pcbs_pkg::CNT_W;
    localparam int MEAN_W   = pcbs_pkg::MEAN_W;
    localparam int DVD_W    = pcbs_pkg::DVD_W;
    localparam int Q_W      = pcbs_pkg::Q_W;
    localparam int ENT_W    = SUM_W + SQ_W + 2 * VAL_BITS;
    localparam int SUM_LO   = ENT_W - SUM_W;
    localparam int SQ_LO    = SUM_LO - SQ_W;
    localparam logic [15:0]        CLS_LIM  = 16'(CLASSES);
    localparam logic [CLS_AW-1:0]  CLS_LAST = CLS_AW'(CLASSES - 1);

    pcbs_pkg::state_t state_reg, state_next;

    // configuration registers
    logic        nodata_en_reg;
    logic [15:0] nodata_val_reg;

    // latched input beat
    logic [1:0]            func_reg;
    logic [15:0]           cls_reg;
    logic [5:0]            band_reg;
    logic [VAL_BITS-1:0]   val_reg;
    logic [15:0]           raw_reg;
    logic                  last_reg;
    logic [2*VAL_BITS-1:0] sq_reg;
    logic [CLS_AW-1:0]     cls_idx_reg;
    logic [ENT_AW-1:0]     ent_addr_reg;

    logic              skip_reg;
    logic [CLS_AW-1:0] clr_cnt_reg;
    logic [1:0]        status_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [SQ_W-1:0]   mm_reg;
    logic [31:0]       sd_reg;

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [31:0] m_count_reg;
    logic [15:0] m_min_reg;
    logic [15:0] m_max_reg;
    logic [23:0] m_mean_reg;
    logic [23:0] m_sd_reg;

    // memories
    logic              cnt_we;
    logic [CLS_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic              ent_we;
    logic [ENT_W-1:0]  ent_wdata;
    logic [ENT_W-1:0]  ent_rdata;
    logic              accept;
    logic [CLS_AW-1:0] cls_idx_in;
    logic [ENT_AW-1:0] ent_addr_in;

    // control outputs
    logic exec_acc;
    logic div_start;
    logic sqrt_start;
    logic out_load;

    // arithmetic units
    logic [DVD_W-1:0]       div_dividend;
    logic [DVD_W-1:0]       div_quotient;
    pcbs_pkg::unit_stat_t   div_stat;
    logic [SQ_W-1:0]        sqrt_in;
    logic [SQ_W/2-1:0]      sqrt_root;
    pcbs_pkg::unit_stat_t   sqrt_stat;

    // entry fields as read
    logic [SUM_W-1:0]    sum_rd;
    logic [SQ_W-1:0]     sq_rd;
    logic [VAL_BITS-1:0] min_rd;
    logic [VAL_BITS-1:0] max_rd;

    // accumulate terms
    logic                cls_ok;
    logic                cls_in;
    logic                band_ok;
    logic                band0;
    logic                nodata_hit;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    acc_cnt;
    logic                acc_upd;
    logic                skip_acc;
    logic                init;
    logic [SUM_W:0]      sum_add;
    logic [SQ_W:0]       sq_add;
    logic [SUM_W-1:0]    sum_new;
    logic [SQ_W-1:0]     sq_new;
    logic [VAL_BITS-1:0] min_new;
    logic [VAL_BITS-1:0] max_new;
    logic                read_range;

    // read math terms
    logic [31:0]     mean_lo;
    logic [SQ_W-1:0] mm_prod;
    logic [SQ_W-1:0] msq_val;

    // apb register port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodata_en_reg  <= 1'b0;
            nodata_val_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                pcbs_pkg::REG_NODATA_EN:  nodata_en_reg  <= pwdata[0];
                pcbs_pkg::REG_NODATA_VAL: nodata_val_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pcbs_pkg::REG_NODATA_EN:  prdata = {31'd0, nodata_en_reg};
            pcbs_pkg::REG_NODATA_VAL: prdata = {16'd0, nodata_val_reg};
            default:                  prdata = '0;
        endcase
    end

    // read addresses from the incoming beat
    assign accept      = s_valid && s_ready;
    assign cls_idx_in  = s_class_id[CLS_AW-1:0];
    assign ent_addr_in = ENT_AW'(cls_idx_in) * ENT_AW'(BANDS) + ENT_AW'(s_band_index);

    // latch the beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            cls_reg      <= s_class_id;
            band_reg     <= s_band_index;
            val_reg      <= s_sample[VAL_BITS-1:0];
            raw_reg      <= s_sample;
            last_reg     <= s_last_band;
            sq_reg       <= s_sample[VAL_BITS-1:0] * s_sample[VAL_BITS-1:0];
            cls_idx_reg  <= cls_idx_in;
            ent_addr_reg <= ent_addr_in;
        end
    end

    pcbs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CLASSES)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (cls_idx_in),
        .rdata (cnt_rdata)
    );

    pcbs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_addr_reg),
        .wdata (ent_wdata),
        .re    (accept),
        .raddr (ent_addr_in),
        .rdata (ent_rdata)
    );

    assign sum_rd = ent_rdata[ENT_W-1:SUM_LO];
    assign sq_rd  = ent_rdata[SUM_LO-1:SQ_LO];
    assign min_rd = ent_rdata[SQ_LO-1:VAL_BITS];
    assign max_rd = ent_rdata[VAL_BITS-1:0];

    // class and band checks
    assign cls_in     = !cls_reg[15] && (cls_reg < CLS_LIM);
    assign cls_ok     = cls_in && (cls_reg != 16'd0);
    assign band_ok    = {26'd0, band_reg} < 32'(BANDS);
    assign band0      = band_reg == 6'd0;
    assign nodata_hit = nodata_en_reg && (raw_reg == nodata_val_reg);
    assign read_range = !cls_in || !band_ok;

    // pixel count and skip decision
    assign cnt_inc  = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
    assign acc_cnt  = band0 ? cnt_inc : cnt_rdata;
    assign acc_upd  = band0 ? (cls_ok && !nodata_hit)
                            : (!skip_reg && cls_ok && band_ok && (cnt_rdata != '0));
    assign skip_acc = last_reg ? 1'b1 : (band0 ? !(cls_ok && !nodata_hit) : skip_reg);
    assign init     = acc_cnt == CNT_W'(1);

    // saturating entry update
    assign sum_add = {1'b0, sum_rd} + (SUM_W + 1)'(val_reg);
    assign sq_add  = {1'b0, sq_rd} + (SQ_W + 1)'(sq_reg);
    assign sum_new = init ? SUM_W'(val_reg) : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
    assign sq_new  = init ? SQ_W'(sq_reg) : (sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0]);
    assign min_new = (init || (val_reg < min_rd)) ? val_reg : min_rd;
    assign max_new = (init || (val_reg > max_rd)) ? val_reg : max_rd;

    assign ent_wdata = {sum_new, sq_new, min_new, max_new};
    assign ent_we    = exec_acc && acc_upd;

    // count memory writes: clearing sweep or pixel start
    assign cnt_we    = (state_reg == pcbs_pkg::ST_CLEAR) || (exec_acc && band0 && acc_upd);
    assign cnt_waddr = (state_reg == pcbs_pkg::ST_CLEAR) ? clr_cnt_reg : cls_idx_reg;
    assign cnt_wdata = (state_reg == pcbs_pkg::ST_CLEAR) ? '0 : cnt_inc;

    // divider: mean pass, then mean square pass
    assign div_dividend = (state_reg == pcbs_pkg::ST_DIV_MEAN) ? {sq_rd, 16'd0}
                                                               : DVD_W'({sum_rd, 8'd0});

    pcbs_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_rdata),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // square of the mean, saturating
    assign mean_lo = mean_reg[31:0];
    assign mm_prod = mean_lo * mean_lo;

    always_ff @(posedge aclk) begin
        mm_reg <= (mean_reg[MEAN_W-1:32] != '0) ? '1 : mm_prod;
        if ((state_reg == pcbs_pkg::ST_DIV_MEAN) && div_stat.done) begin
            mean_reg <= div_quotient[MEAN_W-1:0];
        end
        if (sqrt_stat.done) begin
            sd_reg <= sqrt_root;
        end
    end

    // clamped variance
    assign msq_val = (div_quotient[DVD_W-1:SQ_W] != '0) ? '1 : div_quotient[SQ_W-1:0];
    assign sqrt_in = (msq_val > mm_reg) ? (msq_val - mm_reg) : '0;

    pcbs_sqrt #(
        .W (SQ_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // state register and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcbs_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            skip_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= (state_reg == pcbs_pkg::ST_CLEAR) ? clr_cnt_reg + 1'b1 : '0;
            if (exec_acc) begin
                skip_reg <= skip_acc;
            end else if ((state_reg == pcbs_pkg::ST_EXEC) && (func_reg == pcbs_pkg::FUNC_CLEAR)) begin
                skip_reg <= 1'b0;
            end
        end
    end

    // result status of a read
    always_ff @(posedge aclk) begin
        if (state_reg == pcbs_pkg::ST_EXEC) begin
            if (read_range) begin
                status_reg <= pcbs_pkg::STAT_RANGE;
            end else if (cnt_rdata == '0) begin
                status_reg <= pcbs_pkg::STAT_EMPTY;
            end else begin
                status_reg <= pcbs_pkg::STAT_OK;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pcbs_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == CLS_LAST) state_next = pcbs_pkg::ST_IDLE;
            end
            pcbs_pkg::ST_IDLE: begin
                if (s_valid) state_next = pcbs_pkg::ST_EXEC;
            end
            pcbs_pkg::ST_EXEC: begin
                case (func_reg)
                    pcbs_pkg::FUNC_CLEAR: state_next = pcbs_pkg::ST_CLEAR;
                    pcbs_pkg::FUNC_READ: begin
                        if (read_range || (cnt_rdata == '0)) state_next = pcbs_pkg::ST_OUT;
                        else                                 state_next = pcbs_pkg::ST_DIV_MEAN;
                    end
                    default: state_next = pcbs_pkg::ST_IDLE;
                endcase
            end
            pcbs_pkg::ST_DIV_MEAN: begin
                if (div_stat.done) state_next = pcbs_pkg::ST_DIV_MSQ;
            end
            pcbs_pkg::ST_DIV_MSQ: begin
                if (div_stat.done) state_next = pcbs_pkg::ST_SQRT;
            end
            pcbs_pkg::ST_SQRT: begin
                if (sqrt_stat.done) state_next = pcbs_pkg::ST_OUT;
            end
            pcbs_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = pcbs_pkg::ST_IDLE;
            end
            default: state_next = pcbs_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready    = 1'b0;
        exec_acc   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            pcbs_pkg::ST_IDLE: s_ready = 1'b1;
            pcbs_pkg::ST_EXEC: begin
                exec_acc  = func_reg == pcbs_pkg::FUNC_ACC;
                div_start = (func_reg == pcbs_pkg::FUNC_READ) && !read_range &&
                            (cnt_rdata != '0);
            end
            pcbs_pkg::ST_DIV_MEAN: div_start  = div_stat.done;
            pcbs_pkg::ST_DIV_MSQ:  sqrt_start = div_stat.done;
            pcbs_pkg::ST_OUT:      out_load   = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_reg;
            if (status_reg == pcbs_pkg::STAT_OK) begin
                m_count_reg <= cnt_rdata;
                m_min_reg   <= 16'(min_rd);
                m_max_reg   <= 16'(max_rd);
                m_mean_reg  <= (mean_reg[MEAN_W-1:Q_W] != '0) ? '1 : mean_reg[Q_W-1:0];
                m_sd_reg    <= (sd_reg[31:Q_W] != '0) ? '1 : sd_reg[Q_W-1:0];
            end else begin
                m_count_reg <= '0;
                m_min_reg   <= '0;
                m_max_reg   <= '0;
                m_mean_reg  <= '0;
                m_sd_reg    <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_pixel_count = m_count_reg;
    assign m_band_min    = m_min_reg;
    assign m_band_max    = m_max_reg;
    assign m_band_mean   = m_mean_reg;
    assign m_band_stddev = m_sd_reg;

`ifndef SYNTHESIS
    // the shared divider is never restarted mid-pass
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // square root starts only off a finished mean square pass
    a_sqrt_order: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_start |-> (div_stat.done && !sqrt_stat.busy))
        else $error("square root started out of order");

    // band entries are written only by an accumulate beat
    a_ent_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ent_we |-> ((state_reg == pcbs_pkg::ST_EXEC) && (func_reg == pcbs_pkg::FUNC_ACC)))
        else $error("band entry written outside accumulate");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("result overwritten before delivery");
`endif

endmodule

`default_nettype wire
